@@ src/ddn_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ddn_pkg
// Shared constants, month tables, constant-multiply and mod-7 helpers, and the
// structs that carry stage results of the date / day number converter.
// ----------------------------------------------------------------------------
package ddn_pkg;

    // Day number of the century origin: 19 * 36524.
    localparam logic [19:0] CENTURY_BASE = 20'd693956;
    // Century origin plus the century's leap days (19 / 4).
    localparam logic [19:0] REV_BASE     = 20'd693960;
    // Reciprocal of 365 scaled by 2^27, exact for offsets below 2^19.
    localparam logic [18:0] RECIP_365    = 19'd367720;
    localparam int          RECIP_SHIFT  = 27;
    localparam int          YEAR_W       = 10;
    localparam int          JDAY_W       = 10;

    // Result of the date to day number path.
    typedef struct packed {
        logic [19:0] day_number;
        logic        bad;
    } t_fwd_res;

    // Corrected year and day within that year.
    typedef struct packed {
        logic [YEAR_W-1:0] iyr;
        logic [JDAY_W-1:0] jl;
        logic              leap;
    } t_yr_res;

    // Recovered calendar date.
    typedef struct packed {
        logic [4:0]        day;
        logic [3:0]        month;
        logic [YEAR_W-1:0] year;
        logic              invalid;
    } t_md_res;

    // Length of a month in a common year; months outside 1..12 give zero.
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of a month in a common year.
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] st;
        unique case (m)
            4'd1:    st = 9'd0;
            4'd2:    st = 9'd31;
            4'd3:    st = 9'd59;
            4'd4:    st = 9'd90;
            4'd5:    st = 9'd120;
            4'd6:    st = 9'd151;
            4'd7:    st = 9'd181;
            4'd8:    st = 9'd212;
            4'd9:    st = 9'd243;
            4'd10:   st = 9'd273;
            4'd11:   st = 9'd304;
            4'd12:   st = 9'd334;
            default: st = 9'd0;
        endcase
        return st;
    endfunction

    // x * 365 as a sum of shifts.
    function automatic logic [18:0] times365(input logic [YEAR_W-1:0] x);
        logic [18:0] w;
        w = {{(19-YEAR_W){1'b0}}, x};
        return (w << 8) + (w << 6) + (w << 5) + (w << 3) + (w << 2) + w;
    endfunction

    // v mod 7, folding 3-bit digits since 8 is 1 mod 7.
    function automatic logic [2:0] mod7_21(input logic [20:0] v);
        logic [5:0] s;
        logic [3:0] t;
        logic [3:0] u;
        s = 6'd0;
        for (int i = 0; i < 7; i++) begin
            s = s + {3'd0, v[3*i +: 3]};
        end
        t = {1'b0, s[5:3]} + {1'b0, s[2:0]};
        u = {3'd0, t[3]} + {1'b0, t[2:0]};
        return (u >= 4'd7) ? 3'(u - 4'd7) : u[2:0];
    endfunction

endpackage
`default_nettype wire

@@ src/ddn_fwd.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ddn_fwd
// Date to day number: checks the date and sums the century base, the year
// days, the leap days and the day of the year.
// ----------------------------------------------------------------------------
module ddn_fwd (
    input  wire logic [4:0]      i_day,
    input  wire logic [3:0]      i_month,
    input  wire logic [6:0]      i_year,
    output ddn_pkg::t_fwd_res    o_res
);
    import ddn_pkg::*;

    logic        leap;
    logic [4:0]  max_day;
    logic        good;
    logic [4:0]  leap_days;
    logic [8:0]  doy;
    logic [19:0] sum;

    // A year divisible by four is a leap year, except year zero.
    assign leap = (i_year[1:0] == 2'd0) && (i_year != 7'd0);

    // Range checks on year, month and day.
    assign max_day = month_len(i_month) + {4'd0, leap && (i_month == 4'd2)};
    assign good    = (i_year <= 7'd99) && (i_month >= 4'd1) && (i_month <= 4'd12) &&
                     (i_day >= 5'd1) && (i_day <= max_day);

    // Leap days: four for the century, plus those of earlier years in it.
    assign leap_days = 5'd4 + ((i_year != 7'd0) ? 5'((i_year - 7'd1) >> 2) : 5'd0);
    assign doy       = month_start(i_month) + {8'd0, leap && (i_month > 4'd2)} +
                       {4'd0, i_day};
    assign sum       = CENTURY_BASE + 20'(times365({3'd0, i_year})) +
                       {15'd0, leap_days} + {11'd0, doy};

    assign o_res.day_number = good ? sum : 20'd0;
    assign o_res.bad        = !good;

endmodule
`default_nettype wire

@@ src/ddn_yrfix.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ddn_yrfix
// Year correction: takes the quotient of the day offset by 365, steps the
// year back when its leap days overshoot, and forms the day within the year.
// ----------------------------------------------------------------------------
module ddn_yrfix (
    input  wire logic [18:0]               i_j,
    input  wire logic [ddn_pkg::YEAR_W-1:0] i_q,
    output ddn_pkg::t_yr_res               o_res
);
    import ddn_pkg::*;

    logic [YEAR_W-1:0] qm;
    logic [18:0]       base_q;
    logic [18:0]       base_m;
    logic [19:0]       diff;
    logic [18:0]       alt;
    logic              back;
    logic [YEAR_W-1:0] iyr;
    logic [JDAY_W-1:0] jr;
    logic              leap;

    // Start of the candidate year and of the one before it.
    assign qm     = i_q - YEAR_W'(1);
    assign base_q = times365(i_q) + 19'(i_q >> 2);
    assign base_m = times365(qm) + 19'(qm >> 2);

    // A negative remainder moves back one year.
    assign diff = {1'b0, i_j} - {1'b0, base_q};
    assign alt  = i_j - base_m;
    assign back = diff[19];
    assign iyr  = back ? qm : i_q;
    assign jr   = back ? alt[JDAY_W-1:0] : diff[JDAY_W-1:0];
    assign leap = (iyr[1:0] == 2'd0) && (iyr != YEAR_W'(0));

    assign o_res.iyr  = iyr;
    assign o_res.jl   = jr + JDAY_W'(leap);
    assign o_res.leap = leap;

endmodule
`default_nettype wire

@@ src/ddn_mdsplit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ddn_mdsplit
// Month and day split: finds the last month whose start lies before the day
// within the year, and falls back to December 31 of the prior year on day 0.
// ----------------------------------------------------------------------------
module ddn_mdsplit (
    input  wire ddn_pkg::t_yr_res i_yr,
    output ddn_pkg::t_md_res      o_res
);
    import ddn_pkg::*;

    logic [10:0]       rem [1:12];
    logic [3:0]        imo;
    logic [10:0]       iday;
    logic              zero;

    // Day within each month, compared in parallel.
    always_comb begin
        for (int m = 1; m <= 12; m++) begin
            rem[m] = {1'b0, i_yr.jl} - {2'b0, month_start(4'(m))} -
                     11'(i_yr.leap && (m > 2));
        end
    end

    // The highest month with a positive day wins; none selects January.
    always_comb begin
        imo  = 4'd1;
        iday = rem[1];
        for (int m = 1; m <= 12; m++) begin
            if (!rem[m][10] && (rem[m] != 11'd0)) begin
                imo  = 4'(m);
                iday = rem[m];
            end
        end
    end

    // Day zero is the last day of the previous year.
    assign zero = (iday == 11'd0);

    assign o_res.invalid = zero && (i_yr.iyr == YEAR_W'(0));
    assign o_res.year    = zero ? (i_yr.iyr - YEAR_W'(1)) : i_yr.iyr;
    assign o_res.month   = zero ? 4'd12 : imo;
    assign o_res.day     = zero ? 5'd31 : iday[4:0];

endmodule
`default_nettype wire

@@ src/date_day_number_converter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// date_day_number_converter
// Converts a two-digit-year date of century 19 to a running day number and
// back, with the weekday of the day number.
// Results pass through four registers: input register, reciprocal multiply
// stage, year correction stage, result register.
// Throughput is one item per cycle while the receiver does not stall; the
// 19x19 reciprocal multiply by 1/365 sets the stage depth. An empty stage
// refills while a later one is stalled.
// Synchronous active-low reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module date_day_number_converter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_req_type,
    input  wire logic [4:0]  i_in_day,
    input  wire logic [3:0]  i_in_month,
    input  wire logic [6:0]  i_in_year,
    input  wire logic [19:0] i_in_day_number,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [19:0]      o_out_day_number,
    output logic [4:0]       o_out_day,
    output logic [3:0]       o_out_month,
    output logic [9:0]       o_out_year,
    output logic [2:0]       o_day_of_week,
    output logic             o_invalid
);
    import ddn_pkg::*;

    // Stage valid bits and load enables.
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    // Input register.
    logic        r_s1_type;
    logic [4:0]  r_s1_day;
    logic [3:0]  r_s1_month;
    logic [6:0]  r_s1_year;
    logic [19:0] r_s1_num;

    // Multiply stage.
    logic              r_s2_type;
    t_fwd_res          r_s2_fwd;
    logic [19:0]       r_s2_wsrc;
    logic [18:0]       r_s2_j;
    logic              r_s2_neg;
    logic [YEAR_W-1:0] r_s2_q;

    // Year correction stage.
    logic     r_s3_type;
    t_fwd_res r_s3_fwd;
    logic [2:0] r_s3_wd;
    logic     r_s3_neg;
    t_yr_res  r_s3_yr;

    // Result register.
    logic [19:0] r_out_day_number;
    logic [4:0]  r_out_day;
    logic [3:0]  r_out_month;
    logic [9:0]  r_out_year;
    logic [2:0]  r_out_wd;
    logic        r_out_invalid;

    t_fwd_res          n_s2_fwd;
    logic [20:0]       j_full;
    logic [37:0]       prod;
    logic [YEAR_W-1:0] n_s2_q;
    t_yr_res           n_s3_yr;
    logic [2:0]        n_s3_wd;
    t_md_res           md;
    logic [19:0]       n_out_day_number;
    logic [4:0]        n_out_day;
    logic [3:0]        n_out_month;
    logic [9:0]        n_out_year;
    logic [2:0]        n_out_wd;
    logic              n_out_invalid;

    // A stage loads when it is empty or the stage after it moves on.
    assign en4     = !r_v4 || !i_stall;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_type  <= i_req_type;
            r_s1_day   <= i_in_day;
            r_s1_month <= i_in_month;
            r_s1_year  <= i_in_year;
            r_s1_num   <= i_in_day_number;
        end
    end

    // Forward conversion and the offset quotient by 365.
    ddn_fwd u_fwd (
        .i_day   (r_s1_day),
        .i_month (r_s1_month),
        .i_year  (r_s1_year),
        .o_res   (n_s2_fwd)
    );

    assign j_full = {1'b0, r_s1_num} - {1'b0, REV_BASE};
    assign prod   = j_full[18:0] * RECIP_365;
    assign n_s2_q = prod[RECIP_SHIFT +: YEAR_W];

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_type <= r_s1_type;
            r_s2_fwd  <= n_s2_fwd;
            r_s2_wsrc <= r_s1_type ? r_s1_num : n_s2_fwd.day_number;
            r_s2_j    <= j_full[18:0];
            r_s2_neg  <= j_full[20];
            r_s2_q    <= n_s2_q;
        end
    end

    // Year correction and weekday of the day number.
    ddn_yrfix u_yrfix (
        .i_j   (r_s2_j),
        .i_q   (r_s2_q),
        .o_res (n_s3_yr)
    );

    assign n_s3_wd = mod7_21({1'b0, r_s2_wsrc} + 21'd6);

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_type <= r_s2_type;
            r_s3_fwd  <= r_s2_fwd;
            r_s3_wd   <= n_s3_wd;
            r_s3_neg  <= r_s2_neg;
            r_s3_yr   <= n_s3_yr;
        end
    end

    // Month and day split.
    ddn_mdsplit u_mdsplit (
        .i_yr  (r_s3_yr),
        .o_res (md)
    );

    // Result per request type; rejects zero all but a day number's weekday.
    always_comb begin
        n_out_day_number = 20'd0;
        n_out_day        = 5'd0;
        n_out_month      = 4'd0;
        n_out_year       = 10'd0;
        n_out_wd         = 3'd0;
        n_out_invalid    = 1'b0;
        if (!r_s3_type) begin
            n_out_invalid = r_s3_fwd.bad;
            if (!r_s3_fwd.bad) begin
                n_out_day_number = r_s3_fwd.day_number;
                n_out_wd         = r_s3_wd;
            end
        end else begin
            n_out_wd = r_s3_wd;
            if (r_s3_neg || md.invalid) begin
                n_out_invalid = 1'b1;
            end else begin
                n_out_day   = md.day;
                n_out_month = md.month;
                n_out_year  = md.year;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_out_day_number <= n_out_day_number;
            r_out_day        <= n_out_day;
            r_out_month      <= n_out_month;
            r_out_year       <= n_out_year;
            r_out_wd         <= n_out_wd;
            r_out_invalid    <= n_out_invalid;
        end
    end

    assign o_out_day_number = r_out_day_number;
    assign o_out_day        = r_out_day;
    assign o_out_month      = r_out_month;
    assign o_out_year       = r_out_year;
    assign o_day_of_week    = r_out_wd;
    assign o_invalid        = r_out_invalid;

endmodule
`default_nettype wire

@@ tb/tb_date_day_number_converter.sv @@
// ----------------------------------------------------------------------------
// tb_date_day_number_converter
// Self-checking bench for the date / day number converter. A behavioral
// predictor computes the expected result of every accepted word; a monitor
// compares each delivered result field by field, in order. Directed corner
// cases come first, then random dates and day numbers under random idling
// on both channels, a stretch at full rate and a drain-and-resume phase.
// ----------------------------------------------------------------------------
module tb_date_day_number_converter;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic {
        REQ_TO_NUMBER = 1'b0,
        REQ_TO_DATE   = 1'b1
    } t_req_kind;

    typedef struct {
        t_req_kind   kind;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [6:0]  year;
        logic [19:0] day_number;
    } t_request;

    typedef struct packed {
        logic [19:0] day_number;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [9:0]  year;
        logic [2:0]  weekday;
        logic        invalid;
    } t_conversion;

    // Calendar constants of the fixed century.
    localparam longint DAYS_BEFORE_CENTURY = 19 * 36524;
    localparam longint CENTURY_LEAP_DAYS   = 19 / 4;
    localparam longint CENTURY_START       = DAYS_BEFORE_CENTURY + CENTURY_LEAP_DAYS;
    localparam longint DAYS_PER_YEAR       = 365;
    localparam int     CYCLE_LIMIT         = 250000;
    localparam int     TAIL_CYCLES         = 8;
    localparam int     MAX_REPORTS         = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_req_type;
    logic [4:0]  i_in_day;
    logic [3:0]  i_in_month;
    logic [6:0]  i_in_year;
    logic [19:0] i_in_day_number;
    logic        o_valid;
    logic        i_stall;
    logic [19:0] o_out_day_number;
    logic [4:0]  o_out_day;
    logic [3:0]  o_out_month;
    logic [9:0]  o_out_year;
    logic [2:0]  o_day_of_week;
    logic        o_invalid;

    t_conversion pending_results[$];
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    int          stall_left = 0;
    bit          stall_enable = 1'b1;
    bit          sender_idle = 1'b1;

    date_day_number_converter uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_in_day         (i_in_day),
        .i_in_month       (i_in_month),
        .i_in_year        (i_in_year),
        .i_in_day_number  (i_in_day_number),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_day_number (o_out_day_number),
        .o_out_day        (o_out_day),
        .o_out_month      (o_out_month),
        .o_out_year       (o_out_year),
        .o_day_of_week    (o_day_of_week),
        .o_invalid        (o_invalid)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Days in a month of a common year.
    function automatic int month_length(input longint m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return 28;
            default:               return 0;
        endcase
    endfunction

    // Days before the first of a month in a common year.
    function automatic int month_offset(input longint m);
        case (m)
            2:       return 31;
            3:       return 59;
            4:       return 90;
            5:       return 120;
            6:       return 151;
            7:       return 181;
            8:       return 212;
            9:       return 243;
            10:      return 273;
            11:      return 304;
            12:      return 334;
            default: return 0;
        endcase
    endfunction

    // Expected result of one request word.
    function automatic t_conversion predict_conversion(input t_request r);
        t_conversion res;
        longint      yr, mo, dd, rem, leap_days, doy, n, adj;
        bit          leap;
        res = '0;
        if (r.kind == REQ_TO_NUMBER) begin
            yr = r.year;
            mo = r.month;
            dd = r.day;
            leap = (yr % 4 == 0) && (yr != 0);
            if (yr > 99 || mo < 1 || mo > 12) begin
                res.invalid = 1'b1;
            end else if (dd < 1 || dd > month_length(mo) + ((leap && mo == 2) ? 1 : 0)) begin
                res.invalid = 1'b1;
            end else begin
                leap_days = CENTURY_LEAP_DAYS;
                if (yr != 0)
                    leap_days += (yr - 1) / 4;
                doy = dd;
                for (longint k = 1; k < mo; k++)
                    doy += month_length(k) + ((leap && k == 2) ? 1 : 0);
                n = DAYS_BEFORE_CENTURY + yr * DAYS_PER_YEAR + leap_days + doy;
                res.day_number = 20'(n);
                res.weekday = 3'((n + 6) % 7);
            end
        end else begin
            n = r.day_number;
            res.weekday = 3'((n + 6) % 7);
            rem = n - CENTURY_START;
            yr = rem / DAYS_PER_YEAR;
            if (rem - (yr * DAYS_PER_YEAR + yr / 4) < 0)
                yr -= 1;
            if (yr < 0) begin
                res.invalid = 1'b1;
            end else begin
                leap = (yr % 4 == 0) && (yr != 0);
                rem = rem - (yr * DAYS_PER_YEAR + yr / 4);
                if (leap)
                    rem += 1;
                // Search the month table from December down.
                adj = 0;
                for (mo = 12; mo > 0; mo--) begin
                    adj = (leap && mo > 2) ? -1 : 0;
                    if (rem - month_offset(mo) + adj > 0)
                        break;
                end
                if (mo == 0)
                    mo = 1;
                dd = rem - month_offset(mo) + adj;
                // A zero day falls back to December 31 of the prior year.
                if (dd == 0) begin
                    yr -= 1;
                    mo = 12;
                    dd = 31;
                end
                if (yr < 0) begin
                    res.invalid = 1'b1;
                end else begin
                    res.day = 5'(dd);
                    res.month = 4'(mo);
                    res.year = 10'(yr);
                end
            end
        end
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic t_request make_date(input int d, input int m, input int y);
        t_request r;
        r.kind = REQ_TO_NUMBER;
        r.day = 5'(d);
        r.month = 4'(m);
        r.year = 7'(y);
        r.day_number = 20'($urandom);
        return r;
    endfunction

    function automatic t_request make_number(input longint n);
        t_request r;
        r.kind = REQ_TO_DATE;
        r.day = 5'($urandom);
        r.month = 4'($urandom);
        r.year = 7'($urandom);
        r.day_number = 20'(n);
        return r;
    endfunction

    // Random request: mostly well-formed, with boundary cases and noise.
    function automatic t_request rand_request(input t_req_kind kind);
        t_request r;
        int       pick;
        int       last_day;
        longint   yr;
        r.kind = kind;
        r.day = 5'($urandom);
        r.month = 4'($urandom);
        r.year = 7'($urandom);
        r.day_number = 20'($urandom);
        pick = $urandom_range(0, 99);
        if (kind == REQ_TO_NUMBER) begin
            if (pick < 88) begin
                r.year = 7'($urandom_range(0, 99));
                r.month = 4'($urandom_range(1, 12));
                last_day = month_length(r.month);
                if (r.month == 2 && r.year % 4 == 0 && r.year != 0)
                    last_day += 1;
                if (pick < 76)
                    r.day = 5'($urandom_range(1, last_day));
                else if (pick < 84)
                    r.day = 5'(last_day + $urandom_range(0, 1));
                else
                    r.day = 5'd0;
            end
        end else begin
            if (pick < 60) begin
                r.day_number = 20'($urandom_range(693900, 730540));
            end else if (pick < 80) begin
                // Just around a year boundary.
                yr = $urandom_range(0, 110);
                r.day_number = 20'(CENTURY_START + yr * DAYS_PER_YEAR + yr / 4
                                   + $urandom_range(0, 3) - 1);
            end else if (pick < 85) begin
                r.day_number = 20'($urandom_range(0, 693960));
            end
        end
        return r;
    endfunction

    // Present one word and hold it until accepted.
    task automatic send_word(input t_request r);
        int gap;
        gap = sender_idle ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= r.kind;
        i_in_day <= r.day;
        i_in_month <= r.month;
        i_in_year <= r.year;
        i_in_day_number <= r.day_number;
        do
            @(posedge i_clk);
        while (o_stall !== 1'b0);
        pending_results.push_back(predict_conversion(r));
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_date_corners();
        send_word(make_date(1, 1, 0));
        send_word(make_date(31, 12, 99));
        send_word(make_date(29, 2, 4));
        send_word(make_date(29, 2, 96));
        send_word(make_date(29, 2, 0));
        send_word(make_date(28, 2, 0));
        send_word(make_date(29, 2, 1));
        send_word(make_date(0, 5, 10));
        send_word(make_date(31, 4, 10));
        send_word(make_date(30, 4, 10));
        send_word(make_date(15, 0, 10));
        send_word(make_date(15, 13, 10));
        send_word(make_date(15, 15, 10));
        send_word(make_date(1, 1, 100));
        send_word(make_date(31, 15, 127));
    endtask

    task automatic test_number_corners();
        // Day number zero, the century start, the first leap year's start.
        send_word(make_number(0));
        send_word(make_number(1));
        send_word(make_number(CENTURY_START - 1));
        send_word(make_number(CENTURY_START));
        send_word(make_number(CENTURY_START + 1));
        send_word(make_number(CENTURY_START + DAYS_PER_YEAR));
        send_word(make_number(CENTURY_START + 4 * DAYS_PER_YEAR));
        send_word(make_number(CENTURY_START + 4 * DAYS_PER_YEAR + 1));
        send_word(make_number(CENTURY_START + 4 * DAYS_PER_YEAR + 60));
        send_word(make_number(730484));
        send_word(make_number(20'hFFFFF));
    endtask

    task automatic test_random_dates();
        repeat (400) send_word(rand_request(REQ_TO_NUMBER));
    endtask

    task automatic test_random_numbers();
        repeat (400) send_word(rand_request(REQ_TO_DATE));
    endtask

    // Full rate on both channels.
    task automatic test_back_to_back();
        sender_idle = 1'b0;
        stall_enable = 1'b0;
        repeat (120) send_word(rand_request(t_req_kind'($urandom_range(0, 1))));
        sender_idle = 1'b1;
        stall_enable = 1'b1;
    endtask

    // Let the pipeline run dry between bursts, then resume.
    task automatic test_drain_pause();
        repeat (4) begin
            repeat (25) send_word(rand_request(t_req_kind'($urandom_range(0, 1))));
            wait_drained();
        end
    endtask

    // Receiver stall pattern.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
                if (stall_enable)
                    stall_left = pick_gap();
            end
        end
    end

    // Result monitor: compare each delivered word with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_conversion want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result word: num=%0d day=%0d mon=%0d yr=%0d wd=%0d inv=%0b",
                             o_out_day_number, o_out_day, o_out_month, o_out_year,
                             o_day_of_week, o_invalid);
            end else begin
                want = pending_results.pop_front();
                if (o_out_day_number !== want.day_number || o_out_day !== want.day ||
                    o_out_month !== want.month || o_out_year !== want.year ||
                    o_day_of_week !== want.weekday || o_invalid !== want.invalid) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch expected: num=%0d day=%0d mon=%0d yr=%0d wd=%0d inv=%0b",
                                 want.day_number, want.day, want.month, want.year,
                                 want.weekday, want.invalid);
                        $display("         actual:   num=%0d day=%0d mon=%0d yr=%0d wd=%0d inv=%0b",
                                 o_out_day_number, o_out_day, o_out_month, o_out_year,
                                 o_day_of_week, o_invalid);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_date_day_number_converter failed");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req_type <= REQ_TO_NUMBER;
        i_in_day <= '0;
        i_in_month <= '0;
        i_in_year <= '0;
        i_in_day_number <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_date_corners();
        test_number_corners();
        test_random_dates();
        test_random_numbers();
        test_back_to_back();
        test_drain_pause();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb_date_day_number_converter passed");
        else
            $display("tb_date_day_number_converter failed");
        $finish;
    end

endmodule
